@@ design/ascf_pkg.sv @@
// ascf_pkg: shared types, constants and the SGR attribute update for the
// ANSI SGR colour filter. No dependencies.
package ascf_pkg;

	localparam logic [7:0] ESC_BYTE   = 8'h1B;
	localparam logic [7:0] CHR_LBRACK = 8'h5B;   // '['
	localparam logic [7:0] CHR_SEMI   = 8'h3B;   // ';'
	localparam logic [7:0] CHR_M      = 8'h6D;   // 'm'
	localparam logic [7:0] CHR_ZERO   = 8'h30;   // '0'
	localparam logic [7:0] CHR_NINE   = 8'h39;   // '9'
	localparam logic [7:0] ATTR_INIT  = 8'h0F;   // white on black
	localparam logic [3:0] BRIGHT     = 4'h8;
	localparam logic [3:0] FG_RESET   = 4'd15;

	localparam logic [7:0] SGR_RESET   = 8'd0;
	localparam logic [7:0] SGR_BOLD    = 8'd1;
	localparam logic [7:0] SGR_FG_LO   = 8'd30;
	localparam logic [7:0] SGR_FG_HI   = 8'd37;
	localparam logic [7:0] SGR_FGB_LO  = 8'd90;
	localparam logic [7:0] SGR_FGB_HI  = 8'd97;
	localparam logic [7:0] SGR_BG_LO   = 8'd40;
	localparam logic [7:0] SGR_BG_HI   = 8'd47;
	localparam logic [7:0] SGR_BGB_LO  = 8'd100;
	localparam logic [7:0] SGR_BGB_HI  = 8'd107;
	localparam logic [7:0] CODE_SAT    = 8'd255;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_CSI  = 3'b100
	} mode_t;

	// New attribute after one SGR code; unknown codes leave it alone.
	function automatic logic [7:0] apply_sgr(input logic [7:0] attr, input logic [7:0] code);
		logic [3:0] fg;
		logic [3:0] bg;
		logic [7:0] d;
		fg = attr[3:0];
		bg = attr[7:4];
		d  = 8'd0;
		if (code == SGR_RESET) begin
			fg = FG_RESET;
			bg = 4'd0;
		end else if (code == SGR_BOLD) begin
			fg = fg | BRIGHT;
		end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
			d  = code - SGR_FG_LO;
			fg = d[3:0];
		end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
			d  = code - SGR_FGB_LO;
			fg = d[3:0] | BRIGHT;
		end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
			d  = code - SGR_BG_LO;
			bg = d[3:0];
		end else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI) begin
			d  = code - SGR_BGB_LO;
			bg = d[3:0] | BRIGHT;
		end
		return {bg, fg};
	endfunction

endpackage

@@ design/ansi_sgr_color_filter_core.sv @@
// A byte that is passed through goes from the input register to the result register and shows
// on out_* from there; out_stall can hold it in either register.
// Throughput: one byte per cycle, sustained while out_stall does not hold the result register.
// Escape bytes and zero bytes produce no output but still take their slot like any other byte.
// Reset (arst_n low, asynchronous): both stages empty, parser in text mode, code cleared,
// colour attribute 0x0F (white on black). The attribute survives a zero byte.
module ansi_sgr_color_filter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic [7:0] out_attr
);
	import ascf_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	mode_t      mode_q;
	logic [7:0] code_q;
	logic       digit_q;
	logic [7:0] attr_q;

	// result register
	logic       valid_s2;
	logic [7:0] char_s2;
	logic [7:0] attr_s2;

	logic       out_free;   // result register can take a new result this cycle
	logic       proc;       // byte in s1 is consumed this cycle
	logic       load_s1;

	mode_t      mode_d;
	logic [7:0] code_d;
	logic       digit_d;
	logic [7:0] attr_d;
	logic       emit;
	logic       num_hit;
	logic [11:0] acc;
	logic [7:0] sgr_code;

	// The s1 byte only moves on when the result register has room, whether or not
	// it produces a result; keeps control simple and still one byte per cycle.
	assign out_free = !valid_s2 || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign load_s1  = !valid_s1 || proc;
	assign in_stall = !load_s1;

	assign num_hit  = (byte_s1 >= CHR_ZERO) && (byte_s1 <= CHR_NINE);
	// code * 10 + digit, saturating at 255 below
	assign acc      = {1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0}
	                  + {4'b0000, byte_s1 - CHR_ZERO};
	assign sgr_code = digit_q ? code_q : SGR_RESET;

	always_comb begin
		mode_d  = mode_q;
		code_d  = code_q;
		digit_d = digit_q;
		attr_d  = attr_q;
		emit    = 1'b0;
		if (byte_s1 == 8'd0) begin
			// end of string: parser back to text, colour kept
			mode_d  = MODE_TEXT;
			code_d  = 8'd0;
			digit_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_CSI: begin
					if (num_hit) begin
						code_d  = (acc > {4'b0000, CODE_SAT}) ? CODE_SAT : acc[7:0];
						digit_d = 1'b1;
					end else begin
						// ';' applies and stays; 'm' applies and ends; anything else ends
						if (byte_s1 == CHR_SEMI || byte_s1 == CHR_M)
							attr_d = apply_sgr(attr_q, sgr_code);
						if (byte_s1 != CHR_SEMI)
							mode_d = MODE_TEXT;
						code_d  = 8'd0;
						digit_d = 1'b0;
					end
				end
				MODE_ESC: begin
					if (byte_s1 == CHR_LBRACK) begin
						mode_d  = MODE_CSI;
						code_d  = 8'd0;
						digit_d = 1'b0;
					end else if (byte_s1 == ESC_BYTE) begin
						mode_d = MODE_ESC;
					end else begin
						// lone ESC dropped, byte treated as text
						mode_d = MODE_TEXT;
						emit   = 1'b1;
					end
				end
				default: begin
					if (byte_s1 == ESC_BYTE) begin
						mode_d = MODE_ESC;
					end else begin
						mode_d = MODE_TEXT;
						emit   = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			code_q  <= 8'd0;
			digit_q <= 1'b0;
			attr_q  <= ATTR_INIT;
		end else if (proc) begin
			mode_q  <= mode_d;
			code_q  <= code_d;
			digit_q <= digit_d;
			attr_q  <= attr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= proc && emit;
		end
	end

	// text bytes carry the attribute in force before this byte (text never changes it)
	always_ff @(posedge clk) begin
		if (proc && emit) begin
			char_s2 <= byte_s1;
			attr_s2 <= attr_q;
		end
	end

	assign out_valid = valid_s2;
	assign out_char  = char_s2;
	assign out_attr  = attr_s2;

endmodule

@@ design/ascf_checker.sv @@
// ascf_checker: port-level assertions for ansi_sgr_color_filter_core, plus its bind.
// Depends on ascf_pkg for byte codes and on the top level's ports.
module ascf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic [7:0] out_attr
);
	import ascf_pkg::*;

	// zero bytes and ESC are never passed through
	a_no_ctrl_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char != 8'h00 && out_char != ESC_BYTE))
		else $error("zero or ESC byte emitted");

	// input only backs up when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// a result held under stall stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_char) && $stable(out_attr)))
		else $error("stalled result changed");

	// a stalled input transfer is held by the sender
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(in_byte)))
		else $error("stalled input changed");

	// no new result without a matching earlier input transfer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid) && out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input transfer");

endmodule

bind ansi_sgr_color_filter_core ascf_checker u_ascf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_byte   (in_byte),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.out_attr  (out_attr)
);

@@ test/ansi_sgr_color_filter_checker.sv @@
// Channel monitor and scoreboard for ansi_sgr_color_filter_core: tracks the colour state
// from accepted input transfers and compares every output transfer against it.
// Depends on ascf_pkg for byte codes, SGR code ranges and the parser mode type.
`timescale 1ns / 100ps
module ansi_sgr_color_filter_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_char,
	input  logic [7:0] out_attr,
	output int         mismatches,
	output int         due_count,
	output int         glyphs_checked
);
	import ascf_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
	} glyph_t;

	glyph_t     glyphs_due[$];
	glyph_t     oldest;
	mode_t      mode;
	logic [7:0] code;
	logic       digit_seen;
	logic [7:0] attr;
	int         err_n;
	int         ok_n;

	// Colour attribute after one SGR code; anything outside the known ranges is ignored.
	function automatic logic [7:0] sgr_update(input logic [7:0] cur, input logic [7:0] sgr);
		logic [3:0] fg;
		logic [3:0] bg;
		logic [7:0] off;
		fg  = cur[3:0];
		bg  = cur[7:4];
		off = 8'd0;
		if (sgr == SGR_RESET) begin
			fg = FG_RESET;
			bg = 4'd0;
		end else if (sgr == SGR_BOLD) begin
			fg[3] = 1'b1;
		end else if (sgr >= SGR_FG_LO && sgr <= SGR_FG_HI) begin
			off = sgr - SGR_FG_LO;
			fg  = {1'b0, off[2:0]};
		end else if (sgr >= SGR_FGB_LO && sgr <= SGR_FGB_HI) begin
			off = sgr - SGR_FGB_LO;
			fg  = {1'b1, off[2:0]};
		end else if (sgr >= SGR_BG_LO && sgr <= SGR_BG_HI) begin
			off = sgr - SGR_BG_LO;
			bg  = {1'b0, off[2:0]};
		end else if (sgr >= SGR_BGB_LO && sgr <= SGR_BGB_HI) begin
			off = sgr - SGR_BGB_LO;
			bg  = {1'b1, off[2:0]};
		end
		return {bg, fg};
	endfunction

	// Plain text: ESC opens an escape, anything else goes out with the current colour.
	task automatic take_text(input logic [7:0] b);
		glyph_t g;
		if (b == ESC_BYTE) begin
			mode = MODE_ESC;
		end else begin
			mode   = MODE_TEXT;
			g.ch   = b;
			g.attr = attr;
			glyphs_due.push_back(g);
		end
	endtask

	task automatic track_byte(input logic [7:0] b);
		int acc;
		if (b == 8'h00) begin
			// end of string: parser back to text, colour kept
			mode       = MODE_TEXT;
			code       = 8'd0;
			digit_seen = 1'b0;
		end else if (mode == MODE_ESC) begin
			if (b == CHR_LBRACK) begin
				mode       = MODE_CSI;
				code       = 8'd0;
				digit_seen = 1'b0;
			end else begin
				take_text(b);
			end
		end else if (mode == MODE_CSI) begin
			if (b >= CHR_ZERO && b <= CHR_NINE) begin
				acc        = int'(code) * 10 + int'(b) - int'(CHR_ZERO);
				code       = (acc > 255) ? CODE_SAT : acc[7:0];
				digit_seen = 1'b1;
			end else if (b == CHR_SEMI) begin
				attr       = sgr_update(attr, digit_seen ? code : SGR_RESET);
				code       = 8'd0;
				digit_seen = 1'b0;
			end else begin
				// 'm' applies the code; any other byte just ends the sequence
				if (b == CHR_M)
					attr = sgr_update(attr, digit_seen ? code : SGR_RESET);
				mode       = MODE_TEXT;
				code       = 8'd0;
				digit_seen = 1'b0;
			end
		end else begin
			take_text(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = MODE_TEXT;
			code       = 8'd0;
			digit_seen = 1'b0;
			attr       = ATTR_INIT;
			err_n      = 0;
			ok_n       = 0;
			glyphs_due.delete();
			mismatches     <= 0;
			due_count      <= 0;
			glyphs_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (glyphs_due.size() == 0) begin
					$error("unexpected output transfer: char %02h attr %02h",
						out_char, out_attr);
					err_n++;
				end else begin
					oldest = glyphs_due.pop_front();
					if (out_char !== oldest.ch) begin
						$error("out_char mismatch: expected %02h, got %02h",
							oldest.ch, out_char);
						err_n++;
					end
					if (out_attr !== oldest.attr) begin
						$error("out_attr mismatch: expected %02h, got %02h",
							oldest.attr, out_attr);
						err_n++;
					end
					ok_n++;
				end
			end
			if (in_valid && !in_stall)
				track_byte(in_byte);
			mismatches     <= err_n;
			due_count      <= glyphs_due.size();
			glyphs_checked <= ok_n;
		end
	end

endmodule

@@ test/tb.sv @@
// Testbench top for ansi_sgr_color_filter_core: clock, reset, byte stream and output stall.
// Depends on ascf_pkg, the core, and ansi_sgr_color_filter_checker for the scoreboard checks.
`timescale 1ns / 100ps
module tb;
	import ascf_pkg::*;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic [7:0] out_attr;

	int mismatches;
	int due_count;
	int glyphs_checked;

	// run bookkeeping
	int bytes_sent = 0;
	int sgr_sent   = 0;
	bit send_idle  = 1'b0;   // sender may insert gaps
	bit sink_idle  = 1'b0;   // receiver may stall

	logic [7:0] opening[$];

	ansi_sgr_color_filter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.out_attr  (out_attr)
	);

	ansi_sgr_color_filter_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_char       (out_char),
		.out_attr       (out_attr),
		.mismatches     (mismatches),
		.due_count      (due_count),
		.glyphs_checked (glyphs_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (every byte gapped and every result stalled).
	initial begin
		#2_000_000;
		$display("ansi_sgr_color_filter_core verification failed");
		$finish;
	end

	// Receiver side: random stall bursts while sink_idle is set.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_idle && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// One input transfer, optionally preceded by a gap. Valid stays high afterwards so
	// back-to-back bytes need no second assignment in the same step.
	task automatic send_byte(input logic [7:0] b);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Ordinary text, never zero or ESC, so each byte should come out.
	task automatic send_text(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(1, 255));
			if (b == ESC_BYTE)
				b = 8'h20;
			send_byte(b);
		end
	endtask

	// Decimal digits of one SGR code: known codes, unknown ones, saturating ones or none.
	task automatic send_code();
		int    n;
		string s;
		case ($urandom_range(0, 7))
			0: n = 0;
			1: n = 1;
			2: n = $urandom_range(30, 37);
			3: n = $urandom_range(90, 97);
			4: n = $urandom_range(40, 47);
			5: n = $urandom_range(100, 107);
			6: n = $urandom_range(2, 256);
			default: n = $urandom_range(250, 99999);
		endcase
		s = $sformatf("%0d", n);
		if ($urandom_range(0, 7) == 0)
			s = {"0", s};
		if ($urandom_range(0, 9) == 0)
			s = "";
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// ESC [ codes ; ... terminator. Mostly 'm', sometimes a stray byte that aborts it.
	task automatic send_sgr();
		int         n;
		logic [7:0] t;
		n = $urandom_range(1, 4);
		send_byte(ESC_BYTE);
		send_byte(CHR_LBRACK);
		for (int i = 0; i < n; i++) begin
			send_code();
			if (i < n - 1)
				send_byte(CHR_SEMI);
		end
		t = CHR_M;
		if ($urandom_range(0, 7) == 0) begin
			t = 8'($urandom_range(1, 255));
			if ((t >= CHR_ZERO && t <= CHR_NINE) || t == CHR_SEMI)
				t = 8'h6B;
		end
		send_byte(t);
		sgr_sent++;
	endtask

	// Hold the sender off until every expected character has come out.
	task automatic drain_out();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
	endtask

	initial begin
		int target;
		int next_flip;
		int r;
		bit paused;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: byte extremes, bright colours, lone ESC, double ESC,
		// empty code, saturation, aborted sequence, zero byte inside CSI, bare 'm'.
		opening = '{8'h01, 8'hFF,
			ESC_BYTE, CHR_LBRACK, "1", CHR_SEMI, "1", "0", "7", CHR_M, "A",
			ESC_BYTE, "q",
			ESC_BYTE, ESC_BYTE, CHR_LBRACK, CHR_SEMI, "9", "9", "9", "9", CHR_M, 8'h80,
			ESC_BYTE, CHR_LBRACK, "3", 8'h6B,
			ESC_BYTE, CHR_LBRACK, "4", 8'h00, CHR_M,
			ESC_BYTE, CHR_LBRACK, CHR_M, 8'h7F};
		foreach (opening[i])
			send_byte(opening[i]);
		drain_out();

		// Random part: mostly well-formed SGR sequences with text between them,
		// plus broken escapes, zero bytes and raw noise.
		target    = bytes_sent + 2000;
		next_flip = bytes_sent;
		paused    = 1'b0;
		while (bytes_sent < target) begin
			if (bytes_sent >= next_flip) begin
				send_idle = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
				next_flip = bytes_sent + $urandom_range(50, 200);
			end
			// final stretch at full rate on both sides
			if (bytes_sent > target - 250) begin
				send_idle = 1'b0;
				sink_idle = 1'b0;
			end
			if (!paused && bytes_sent > target - 1000) begin
				drain_out();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_sgr();
				send_text($urandom_range(1, 6));
			end else if (r < 72) begin
				send_text($urandom_range(1, 8));
			end else if (r < 82) begin
				// ESC not followed by '[' (may itself be another ESC)
				send_byte(ESC_BYTE);
				send_byte($urandom_range(0, 5) == 0 ? ESC_BYTE : 8'($urandom_range(1, 90)));
			end else if (r < 88) begin
				// string ends in the middle of a sequence
				send_byte(ESC_BYTE);
				if ($urandom_range(0, 1) == 1) begin
					send_byte(CHR_LBRACK);
					send_code();
				end
				send_byte(8'h00);
			end else if (r < 92) begin
				send_byte(8'h00);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end

		drain_out();
		repeat (8) @(posedge clk);

		$display("Summary: %0d bytes sent, %0d characters checked, %0d SGR sequences",
			bytes_sent, glyphs_checked, sgr_sent);
		$display("Summary: random gaps and stalls, one full drain mid-run, full-rate tail");
		if (mismatches == 0)
			$display("ansi_sgr_color_filter_core verification clean");
		else
			$display("ansi_sgr_color_filter_core verification failed");
		$finish;
	end

endmodule
